### rtl/core/wsd_pkg.sv
package wsd_pkg;

    // operation codes of an input word
    localparam logic OPER_BYTE = 1'b0;
    localparam logic OPER_OPEN = 1'b1;

    // frame opcodes that trigger an action
    localparam logic [3:0] OP_CLOSE = 4'd8;
    localparam logic [3:0] OP_PING  = 4'd9;

    // header byte counts: two header bytes, then four key bytes
    localparam logic [2:0] HDR_KEY_START = 3'd2;
    localparam logic [2:0] HDR_LAST_KEY  = 3'd5;
    localparam logic [2:0] HDR_LEN       = 3'd6;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_PONG  = 2'd1,
        ACT_CLOSE = 2'd2,
        ACT_DROP  = 2'd3
    } action_t;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        logic       has_payload;
        logic [7:0] payload_byte;
        logic       frame_end;
        logic [3:0] frame_opcode;
        action_t    action;
    } result_t;

    typedef struct packed {
        logic            connected;
        logic [2:0]      hdr_count;
        logic [3:0]      opcode;
        logic            mask_flag;
        logic [6:0]      rem_len;
        logic [3:0][7:0] mask_key;
        logic [1:0]      key_index;
    } dec_state_t;

    localparam dec_state_t DEC_RESET = '{
        connected: 1'b0,
        hdr_count: 3'd0,
        opcode:    OP_CLOSE,
        mask_flag: 1'b0,
        rem_len:   7'd0,
        mask_key:  32'd0,
        key_index: 2'd0
    };

endpackage

### rtl/core/wsd_if.sv
// input words: operation and received byte
interface wsd_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

// result words of the deframer
interface wsd_out_if;
    import wsd_pkg::*;

    logic       valid;
    logic       ready;
    logic       has_payload;
    logic [7:0] payload_byte;
    logic       frame_end;
    logic [3:0] frame_opcode;
    action_t    action;

    modport source (
        output valid, output has_payload, output payload_byte, output frame_end,
        output frame_opcode, output action, input ready
    );
    modport sink (
        input valid, input has_payload, input payload_byte, input frame_end,
        input frame_opcode, input action, output ready
    );
endinterface

### rtl/core/wsd_in_stage.sv
module wsd_in_stage (
    input  logic             clk,
    input  logic             rst_n,
    wsd_in_if.sink           link,
    input  logic             take,
    output logic             item_valid,
    output wsd_pkg::in_word_t item
);
    import wsd_pkg::*;

    logic     valid_reg;
    in_word_t word_reg;

    // register is free when empty or drained this cycle
    assign link.ready = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = word_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (link.ready)
        begin
            valid_reg <= link.valid;
        end
    end

    // word capture
    always_ff @(posedge clk)
    begin
        if (link.ready && link.valid)
        begin
            word_reg <= '{operation: link.operation, rx_byte: link.rx_byte};
        end
    end

endmodule

### rtl/core/wsd_decode.sv
module wsd_decode (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  wsd_pkg::in_word_t item,
    input  logic              out_ready,
    output logic              take,
    output logic              res_valid,
    output wsd_pkg::result_t  res
);
    import wsd_pkg::*;

    dec_state_t st_reg;
    dec_state_t st_next;
    logic [1:0] key_sel;
    logic [7:0] key_byte;
    logic [7:0] data;
    logic [6:0] len_dec;
    action_t    end_action;

    // one word per cycle whenever the result register can take it
    assign take = item_valid && out_ready;

    // datapath helpers
    assign key_sel  = 2'(st_reg.hdr_count - HDR_KEY_START);
    assign key_byte = st_reg.mask_key[st_reg.key_index];
    assign data     = st_reg.mask_flag ? (item.rx_byte ^ key_byte) : item.rx_byte;
    assign len_dec  = st_reg.rem_len - 7'd1;

    // action taken when the frame completes
    always_comb
    begin
        case (st_reg.opcode)
            OP_PING:  end_action = ACT_PONG;
            OP_CLOSE: end_action = ACT_CLOSE;
            default:  end_action = ACT_NONE;
        endcase
    end

    // frame decoding
    always_comb
    begin
        st_next   = st_reg;
        res_valid = 1'b0;
        res       = '{has_payload: 1'b0, payload_byte: 8'd0, frame_end: 1'b0,
                      frame_opcode: st_reg.opcode, action: ACT_NONE};
        if (take)
        begin
            if (item.operation == OPER_OPEN)
            begin
                st_next           = DEC_RESET;
                st_next.connected = 1'b1;
            end
            else if (!st_reg.connected)
            begin
                st_next = st_reg;
            end
            else if (st_reg.hdr_count == 3'd0)
            begin
                st_next.opcode    = item.rx_byte[3:0];
                st_next.hdr_count = 3'd1;
            end
            else if (st_reg.hdr_count == 3'd1)
            begin
                if (!item.rx_byte[7])
                begin
                    // unmasked header drops the connection
                    res_valid  = 1'b1;
                    res.action = ACT_DROP;
                    st_next    = DEC_RESET;
                end
                else
                begin
                    st_next.hdr_count = HDR_KEY_START;
                    st_next.mask_flag = 1'b1;
                    st_next.rem_len   = item.rx_byte[6:0];
                end
            end
            else if (st_reg.mask_flag && st_reg.hdr_count < HDR_LEN)
            begin
                // mask key bytes
                st_next.mask_key[key_sel] = item.rx_byte;
                st_next.hdr_count         = st_reg.hdr_count + 3'd1;
                if (st_reg.hdr_count == HDR_LAST_KEY)
                begin
                    st_next.key_index = 2'd0;
                    if (st_reg.rem_len == 7'd0)
                    begin
                        // empty frame completes with its last key byte
                        res_valid         = 1'b1;
                        res.frame_end     = 1'b1;
                        res.action        = end_action;
                        st_next           = DEC_RESET;
                        st_next.connected = (end_action != ACT_CLOSE);
                    end
                end
            end
            else if (st_reg.rem_len != 7'd0)
            begin
                // payload byte
                res_valid         = 1'b1;
                res.has_payload   = 1'b1;
                res.payload_byte  = data;
                st_next.rem_len   = len_dec;
                if (st_reg.mask_flag)
                begin
                    st_next.key_index = st_reg.key_index + 2'd1;
                end
                if (len_dec == 7'd0)
                begin
                    res.frame_end     = 1'b1;
                    res.action        = end_action;
                    st_next           = DEC_RESET;
                    st_next.connected = (end_action != ACT_CLOSE);
                end
            end
        end
    end

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= DEC_RESET;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

`ifndef ASSERT_OFF
    a_close_disconnects: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.action == ACT_CLOSE |=> !st_reg.connected)
        else $error("close frame left the connection open");

    a_hdr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.hdr_count <= HDR_LEN)
        else $error("header count past the key bytes");

    a_open_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        take && item.operation == OPER_OPEN |=> st_reg.connected && st_reg.hdr_count == 3'd0)
        else $error("connection open did not restart decoding");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.frame_end |=> st_reg.hdr_count == 3'd0 && st_reg.rem_len == 7'd0)
        else $error("frame end did not clear the decoder");

    a_result_needs_take: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> take)
        else $error("result without a consumed word");
`endif

endmodule

### rtl/core/wsd_out_stage.sv
module wsd_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    input  wsd_pkg::result_t res,
    output logic             out_ready,
    wsd_out_if.source        deframed
);
    import wsd_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    // free when empty or the word leaves this cycle
    assign out_ready = !valid_reg || deframed.ready;

    assign deframed.valid        = valid_reg;
    assign deframed.has_payload  = res_reg.has_payload;
    assign deframed.payload_byte = res_reg.payload_byte;
    assign deframed.frame_end    = res_reg.frame_end;
    assign deframed.frame_opcode = res_reg.frame_opcode;
    assign deframed.action       = res_reg.action;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            valid_reg <= res_valid;
        end
    end

    // result capture
    always_ff @(posedge clk)
    begin
        if (out_ready && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

### rtl/core/websocket_frame_deframer.sv
// channel    | dir | word contents
// -----------+-----+--------------------------------------------------------
// link       | in  | operation, rx_byte
// deframed   | out | has_payload, payload_byte, frame_end, frame_opcode, action
//
// one word accepted per cycle while deframed is not stalled; a word's result, if it has one,
// passes the input register, the single decode step and then the result register
// reset empties both registers and returns the decoder to disconnected
// a stall on deframed holds the result register and back-pressures link
module websocket_frame_deframer (
    input  logic      clk,
    input  logic      rst_n,
    wsd_in_if.sink    link,
    wsd_out_if.source deframed
);
    import wsd_pkg::*;

    logic     item_valid;
    in_word_t item;
    logic     take;
    logic     out_ready;
    logic     res_valid;
    result_t  res;

    // input register
    wsd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .link       (link),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // header decode and unmasking
    wsd_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_ready  (out_ready),
        .take       (take),
        .res_valid  (res_valid),
        .res        (res)
    );

    // result register
    wsd_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_ready (out_ready),
        .deframed  (deframed)
    );

endmodule

### tb/wsd_deframe_check.sv
`timescale 1ns / 100ps

module wsd_deframe_check
    import wsd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    wsd_in_if    link,
    wsd_out_if   deframed,
    output int   fail_count,
    output int   words_owed
);

    // deframed words predicted but not yet seen
    result_t owed_q[$];
    int errs = 0;

    // predictor copy of the decoder
    logic            link_up    = 1'b0;
    logic [2:0]      hdr_seen   = '0;
    logic [3:0]      frame_op   = OP_CLOSE;
    logic            masked     = 1'b0;
    logic [6:0]      bytes_left = '0;
    logic [3:0][7:0] key        = '0;
    logic [1:0]      key_pos    = '0;

    task automatic report(input string msg);
        $display("%0t ns deframed: %s", $time, msg);
        errs++;
    endtask

    function automatic void clear_frame();
        hdr_seen   = '0;
        frame_op   = OP_CLOSE;
        masked     = 1'b0;
        bytes_left = '0;
        key        = '0;
        key_pos    = '0;
    endfunction

    function automatic void owe(input logic h, input logic [7:0] d, input logic e,
                                input logic [3:0] o, input action_t a);
        result_t r;
        r.has_payload  = h;
        r.payload_byte = d;
        r.frame_end    = e;
        r.frame_opcode = o;
        r.action       = a;
        owed_q.push_back(r);
    endfunction

    // last word of a frame: pick the action from the opcode
    function automatic void close_frame(input logic h, input logic [7:0] d);
        action_t a;
        a = ACT_NONE;
        if (frame_op == OP_PING)
        begin
            a = ACT_PONG;
        end
        else if (frame_op == OP_CLOSE)
        begin
            a = ACT_CLOSE;
            link_up = 1'b0;
        end
        owe(h, d, 1'b1, frame_op, a);
        clear_frame();
    endfunction

    // one accepted link word through the decoder
    function automatic void deframe_word(input logic oper, input logic [7:0] b);
        logic [7:0] data;
        if (oper == OPER_OPEN)
        begin
            link_up = 1'b1;
            clear_frame();
            return;
        end
        if (!link_up)
            return;

        // header bytes
        if (hdr_seen == 3'd0)
        begin
            frame_op = b[3:0];
            hdr_seen = 3'd1;
            return;
        end
        if (hdr_seen == 3'd1)
        begin
            hdr_seen   = HDR_KEY_START;
            masked     = b[7];
            bytes_left = b[6:0];
            if (!masked)
            begin
                owe(1'b0, 8'd0, 1'b0, frame_op, ACT_DROP);
                link_up = 1'b0;
                clear_frame();
            end
            return;
        end

        // mask key bytes, low byte first
        if (masked && hdr_seen < HDR_LEN)
        begin
            key[2'(hdr_seen - HDR_KEY_START)] = b;
            hdr_seen = hdr_seen + 3'd1;
            if (hdr_seen == HDR_LEN)
            begin
                key_pos = '0;
                if (bytes_left == '0)
                    close_frame(1'b0, 8'd0);
            end
            return;
        end

        // payload; stray bytes past the end are dropped
        if (bytes_left != '0)
        begin
            data = b;
            if (masked)
            begin
                data    = b ^ key[key_pos];
                key_pos = key_pos + 2'd1;
            end
            bytes_left = bytes_left - 7'd1;
            if (bytes_left == '0)
                close_frame(1'b1, data);
            else
                owe(1'b1, data, 1'b0, frame_op, ACT_NONE);
        end
    endfunction

    // compare results first, then predict from the input word of the same edge
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (deframed.valid && deframed.ready)
            begin
                if (owed_q.size() == 0)
                begin
                    report($sformatf("word with nothing owed: opcode %0h action %0d",
                                     deframed.frame_opcode, deframed.action));
                end
                else
                begin
                    want = owed_q.pop_front();
                    if (deframed.has_payload !== want.has_payload)
                        report($sformatf("has_payload %b, want %b",
                                         deframed.has_payload, want.has_payload));
                    if (deframed.payload_byte !== want.payload_byte)
                        report($sformatf("payload_byte %h, want %h",
                                         deframed.payload_byte, want.payload_byte));
                    if (deframed.frame_end !== want.frame_end)
                        report($sformatf("frame_end %b, want %b",
                                         deframed.frame_end, want.frame_end));
                    if (deframed.frame_opcode !== want.frame_opcode)
                        report($sformatf("frame_opcode %h, want %h",
                                         deframed.frame_opcode, want.frame_opcode));
                    if (deframed.action !== want.action)
                        report($sformatf("action %0d, want %0d",
                                         deframed.action, want.action));
                end
            end
            if (link.valid && link.ready)
                deframe_word(link.operation, link.rx_byte);
        end
        fail_count <= errs;
        words_owed <= owed_q.size();
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import wsd_pkg::*;

    localparam int ITEMS       = 1350;
    localparam int WHOLE_FRAME = 1000;
    localparam int LONG_HOLD   = 80;

    logic clk;
    logic rst_n;

    int send_idle_pct = 10;
    int recv_idle_pct = 58;
    int words_sent    = 0;
    int hold_requests = 0;
    int holds_done    = 0;
    int long_hold     = 0;
    int fail_count;
    int words_owed;

    wsd_in_if  link();
    wsd_out_if deframed();

    websocket_frame_deframer i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .link     (link),
        .deframed (deframed)
    );

    wsd_deframe_check i_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .link       (link),
        .deframed   (deframed),
        .fail_count (fail_count),
        .words_owed (words_owed)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // result side: random stalls, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            deframed.ready <= 1'b0;
        end
        else if (long_hold > 0)
        begin
            deframed.ready <= 1'b0;
            long_hold      <= long_hold - 1;
        end
        else if (holds_done != hold_requests)
        begin
            deframed.ready <= 1'b0;
            holds_done     <= holds_done + 1;
            long_hold      <= LONG_HOLD;
        end
        else
        begin
            deframed.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // one link word, with random idle cycles ahead of it
    task automatic send_word(input logic oper, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            link.valid <= 1'b0;
            @(posedge clk);
        end
        link.valid     <= 1'b1;
        link.operation <= oper;
        link.rx_byte   <= b;
        @(posedge clk);
        while (!link.ready)
            @(posedge clk);
        words_sent++;
    endtask

    // header, then key and random payload when masked; cut stops the frame early
    task automatic send_frame(input logic [3:0] flags, input logic [3:0] opc,
                              input logic masked, input logic [6:0] len,
                              input logic [31:0] key, input int cut);
        logic [7:0] seq[$];
        seq.push_back({flags, opc});
        seq.push_back({masked, len});
        if (masked)
        begin
            for (int i = 0; i < 4; i++)
                seq.push_back(key[8*i +: 8]);
            for (int i = 0; i < len; i++)
                seq.push_back(8'($urandom));
        end
        for (int i = 0; i < seq.size() && i < cut; i++)
            send_word(OPER_BYTE, seq[i]);
    endtask

    function automatic logic [6:0] pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 2)
            return 7'd127;
        if (r < 6)
            return 7'($urandom_range(127));
        return 7'($urandom_range(10));
    endfunction

    initial
    begin
        logic       link_up;
        logic [3:0] opc;
        logic [6:0] len;
        int         phase;
        int         pick;
        int         guard;

        rst_n          = 1'b0;
        link.valid     = 1'b0;
        link.operation = OPER_BYTE;
        link.rx_byte   = 8'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: masked text frame, empty ping, empty close
        send_word(OPER_OPEN, 8'd0);
        send_frame(4'h8, 4'h1, 1'b1, 7'd3, 32'h5AA5_FF00, WHOLE_FRAME);
        send_frame(4'h8, OP_PING, 1'b1, 7'd0, 32'hFFFF_FFFF, WHOLE_FRAME);
        send_frame(4'h0, OP_CLOSE, 1'b1, 7'd0, 32'h0000_0000, WHOLE_FRAME);
        // byte while disconnected, then an unmasked header
        send_word(OPER_BYTE, 8'hFF);
        send_word(OPER_OPEN, 8'hFF);
        send_word(OPER_BYTE, 8'hFF);
        send_word(OPER_BYTE, 8'h7F);
        link_up = 1'b0;

        // random traffic, mostly well-formed frames
        phase = 0;
        while (words_sent < ITEMS)
        begin
            if (phase == 0 && words_sent >= 450)
            begin
                send_idle_pct = 58;
                recv_idle_pct = 10;
                phase         = 1;
            end
            else if (phase == 1 && words_sent >= 900)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_requests++;
                phase         = 2;
            end

            if (!link_up)
            begin
                if ($urandom_range(99) < 25)
                    repeat ($urandom_range(1, 3)) send_word(OPER_BYTE, 8'($urandom));
                send_word(OPER_OPEN, 8'($urandom));
                link_up = 1'b1;
            end

            opc  = 4'($urandom_range(15));
            len  = pick_len();
            pick = $urandom_range(99);
            if (pick < 78)
            begin
                send_frame(4'($urandom), opc, 1'b1, len, $urandom, WHOLE_FRAME);
                if (opc == OP_CLOSE)
                    link_up = 1'b0;
            end
            else if (pick < 86)
            begin
                send_frame(4'($urandom), opc, 1'b0, len, $urandom, WHOLE_FRAME);
                link_up = 1'b0;
            end
            else if (pick < 94)
            begin
                // frame broken off by a new connection
                send_frame(4'($urandom), opc, 1'b1, len, $urandom,
                           $urandom_range(1, 5 + int'(len)));
                send_word(OPER_OPEN, 8'($urandom));
            end
            else if (pick < 97)
            begin
                send_word(OPER_OPEN, 8'($urandom));
            end
            else
            begin
                // junk bytes, then resync
                repeat ($urandom_range(1, 3)) send_word(OPER_BYTE, 8'($urandom));
                send_word(OPER_OPEN, 8'($urandom));
            end
        end
        link.valid <= 1'b0;

        // drain the deframed side
        @(posedge clk);
        guard = 0;
        while (words_owed != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);

        if (fail_count == 0 && words_owed == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
